[rtl/embd_pkg.sv]
// shared types and constants for the edge mask border dilation block
package embd_pkg;

  // fixed field widths
  localparam int PIX_W      = 10;
  localparam int CFG_W      = 11;
  localparam int ROW_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_HEIGHT = 1024;

  // reset value of both frame size registers
  localparam logic [CFG_W-1:0] DIM_RST = CFG_W'(1024);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // request codes of the input word
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  // input channel word
  typedef struct packed {
    logic req_type;
    logic edge_bit;
    logic border_in;
  } in_item_t;

  // result channel word
  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic             edge_out;
    logic             border_out;
    logic             frame_last;
  } out_item_t;

  // position of the result carried along the pipe
  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             last;
  } res_t;

  // one raster position issued to the column store
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             edge_bit;
    logic             border_bit;
    logic             emit;
    res_t             res;
  } issue_t;

  // column summary handed to the window stage
  typedef struct packed {
    logic v;
    logic col0;
    logic cedge;
    logic cborder;
    logic emit;
    res_t res;
  } colv_t;

  // one tap of the horizontal window
  typedef struct packed {
    logic v;
    logic col0;
    logic cedge;
    logic cborder;
  } tap_t;

endpackage

[rtl/embd_if.sv]
// valid/ready channel interfaces for the input and result words
interface embd_in_if import embd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface embd_out_if import embd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/embd_ctrl.sv]
// frame registers, raster counters, lag counter and flush sequencing
module embd_ctrl import embd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  embd_in_if.sink                       in_chan,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          load_ok,
  output logic                          issue_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]  issue_col,
  output issue_t                        issue
);

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LAG_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

  // clamp of the width register to the supported range
  function automatic logic [W_W-1:0] used_width(input logic [CFG_W-1:0] raw);
    logic [W_W-1:0] w;
    if (raw == '0) begin
      w = W_W'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      w = W_W'(MAX_WIDTH);
    end else begin
      w = W_W'(raw);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] used_height(input logic [CFG_W-1:0] raw);
    logic [ROW_W-1:0] h;
    if (raw == '0) begin
      h = ROW_W'(1);
    end else if (int'(raw) > MAX_HEIGHT) begin
      h = ROW_W'(MAX_HEIGHT);
    end else begin
      h = ROW_W'(raw);
    end
    return h;
  endfunction

  // positions between a pixel and its result: radius rows plus radius pixels
  function automatic logic [LAG_W-1:0] lag_of(input logic [CFG_W-1:0] raw);
    return LAG_W'(RADIUS) * LAG_W'(used_width(raw)) + LAG_W'(RADIUS);
  endfunction

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_nxt;
  logic [W_W-1:0]   in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [LAG_W-1:0] lag_rem_r;
  logic [W_W-1:0]   sched_col_r;
  logic [ROW_W-1:0] sched_row_r;
  logic             gen_r;

  logic [W_W-1:0]   used_w;
  logic [ROW_W-1:0] used_h;
  logic             frame_in;
  logic             accept;
  logic             take_pixel;
  logic             take_flush;
  logic             step;
  logic             emit;
  logic             col_wrap;
  logic             sched_col_wrap;
  logic             sched_last;

  // decode of the current position
  assign used_w         = used_width(width_r);
  assign used_h         = used_height(height_r);
  assign frame_in       = in_row_r >= used_h;
  assign in_chan.ready  = load_ok && !gen_r;
  assign accept         = in_chan.valid && in_chan.ready;
  assign take_pixel     = accept && (in_chan.data.req_type == REQ_PIXEL) && !frame_in;
  assign take_flush     = accept && frame_in;
  assign step           = take_pixel || take_flush || (gen_r && load_ok);
  assign emit           = lag_rem_r == '0;
  assign col_wrap       = in_col_r == used_w - W_W'(1);
  assign sched_col_wrap = sched_col_r == used_w - W_W'(1);
  assign sched_last     = sched_col_wrap && (sched_row_r == used_h - ROW_W'(1));

  assign width_nxt = (cfg_index == REG_FRAME_WIDTH) ? cfg_data : width_r;

  // position issued to the column store
  assign issue_valid     = step;
  assign issue_col       = in_col_r[COL_W-1:0];
  assign issue.row       = in_row_r;
  assign issue.edge_bit  = take_pixel && in_chan.data.edge_bit;
  assign issue.border_bit = take_pixel && in_chan.data.border_in;
  assign issue.emit      = emit;
  assign issue.res.col   = PIX_W'(sched_col_r);
  assign issue.res.row   = sched_row_r[PIX_W-1:0];
  assign issue.res.last  = sched_last;

  // registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      in_col_r    <= '0;
      in_row_r    <= '0;
      sched_col_r <= '0;
      sched_row_r <= '0;
      lag_rem_r   <= lag_of(DIM_RST);
      gen_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
      in_col_r    <= '0;
      in_row_r    <= '0;
      sched_col_r <= '0;
      sched_row_r <= '0;
      lag_rem_r   <= lag_of(width_nxt);
      gen_r       <= 1'b0;
    end else if (step) begin
      if (emit && sched_last) begin
        // last result of the frame: start over
        in_col_r    <= '0;
        in_row_r    <= '0;
        sched_col_r <= '0;
        sched_row_r <= '0;
        lag_rem_r   <= lag_of(width_r);
        gen_r       <= 1'b0;
      end else begin
        if (col_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + W_W'(1);
        end
        if (emit) begin
          if (sched_col_wrap) begin
            sched_col_r <= '0;
            sched_row_r <= sched_row_r + ROW_W'(1);
          end else begin
            sched_col_r <= sched_col_r + W_W'(1);
          end
        end else begin
          lag_rem_r <= lag_rem_r - LAG_W'(1);
        end
        gen_r <= !emit && (gen_r || take_flush);
      end
    end
  end

  // empty positions are only generated once the frame is fully in
  a_gen_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r |-> (in_row_r >= used_h))
    else $error("flush sequencing active before frame complete");

  // a result never overtakes the pixels that produce it
  a_sched_behind: assert property (@(posedge clk) disable iff (!rst_n)
    sched_row_r <= in_row_r)
    else $error("result row ahead of input row");

endmodule

[rtl/embd_colst.sv]
// per-column history store and vertical or over the window rows
module embd_colst import embd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]  issue_col,
  input  issue_t                        issue,
  output logic                          load_ok,
  output logic                          colv_valid,
  output colv_t                         colv,
  input  logic                          win_ready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int E_W    = 2 * RADIUS;
  localparam int HIST_W = 3 * RADIUS;

  // bits [E_W-1:0]: edge of the rows above, nearest first
  // bits [HIST_W-1:E_W]: border of the rows above, nearest first
  logic [HIST_W-1:0] mem [MAX_WIDTH];

  logic              a_valid_r;
  logic [COL_W-1:0]  a_col_r;
  issue_t            a_item_r;
  logic [HIST_W-1:0] rd_q_r;

  logic              advance;
  logic              load;
  logic [E_W-1:0]    edge_hist;
  logic [RADIUS-1:0] border_hist;
  logic [E_W-1:0]    row_ok;
  logic [E_W:0]      esh;
  logic [RADIUS:0]   bsh;
  logic [HIST_W-1:0] wr_data;

  assign advance = a_valid_r && win_ready;
  assign load_ok = !a_valid_r || advance;
  assign load    = issue_valid;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (load) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_col_r  <= issue_col;
      a_item_r <= issue;
    end
  end

  // column store: write back on leave, read on entry with forwarding
  always_ff @(posedge clk) begin
    if (advance) begin
      mem[a_col_r] <= wr_data;
    end
    if (load) begin
      if (advance && (a_col_r == issue_col)) begin
        rd_q_r <= wr_data;
      end else begin
        rd_q_r <= mem[issue_col];
      end
    end
  end

  // history split and rows that lie above the frame top
  assign edge_hist   = rd_q_r[E_W-1:0];
  assign border_hist = rd_q_r[HIST_W-1:E_W];

  always_comb begin
    for (int j = 0; j < E_W; j++) begin
      row_ok[j] = a_item_r.row > ROW_W'(j);
    end
  end

  // shifted history for write back
  assign esh     = {edge_hist, a_item_r.edge_bit};
  assign bsh     = {border_hist, a_item_r.border_bit};
  assign wr_data = {bsh[RADIUS-1:0], esh[E_W-1:0]};

  // column summary: vertical or, centre bits radius rows up
  assign colv_valid   = a_valid_r;
  assign colv.v       = a_item_r.edge_bit || (|(edge_hist & row_ok));
  assign colv.col0    = a_col_r == '0;
  assign colv.cedge   = edge_hist[RADIUS-1];
  assign colv.cborder = border_hist[RADIUS-1];
  assign colv.emit    = a_item_r.emit;
  assign colv.res     = a_item_r.res;

  // a stalled stage keeps its position
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !win_ready) |=> (a_valid_r && $stable(a_col_r)))
    else $error("column stage lost its position while stalled");

endmodule

[rtl/embd_window.sv]
// horizontal window over column summaries and result register
module embd_window import embd_pkg::*; #(
  parameter int RADIUS = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          colv_valid,
  input  colv_t         colv,
  output logic          win_ready,
  embd_out_if.source    out_chan
);

  localparam int TAPS = 2 * RADIUS + 1;

  tap_t            hist_r [1:TAPS-1];
  tap_t            tap    [0:TAPS-1];
  logic [TAPS-1:0] same;
  logic [TAPS-1:0] hit;
  logic            near;
  logic            take;
  logic            out_valid_r;
  out_item_t       out_data_r;

  assign win_ready = !out_valid_r || out_chan.ready;
  assign take      = colv_valid && win_ready;

  // taps, newest first; the centre sits radius taps back
  always_comb begin
    tap[0] = '{v: colv.v, col0: colv.col0, cedge: colv.cedge, cborder: colv.cborder};
    for (int k = 1; k < TAPS; k++) begin
      tap[k] = hist_r[k];
    end
  end

  // keep only taps in the centre's row: a row start between them cuts the window
  always_comb begin
    same[RADIUS] = 1'b1;
    for (int k = RADIUS - 1; k >= 0; k--) begin
      same[k] = same[k+1] && !tap[k].col0;
    end
    for (int k = RADIUS + 1; k < TAPS; k++) begin
      same[k] = same[k-1] && !tap[k-1].col0;
    end
    for (int k = 0; k < TAPS; k++) begin
      hit[k] = tap[k].v && same[k];
    end
  end

  assign near = |hit;

  // tap shift line
  always_ff @(posedge clk) begin
    if (take) begin
      hist_r[1] <= tap[0];
      for (int k = 2; k < TAPS; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && colv.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && colv.emit) begin
      out_data_r.pixel_col  <= colv.res.col;
      out_data_r.pixel_row  <= colv.res.row;
      out_data_r.edge_out   <= tap[RADIUS].cedge;
      out_data_r.border_out <= tap[RADIUS].cborder || (near && !tap[RADIUS].cedge);
      out_data_r.frame_last <= colv.res.last;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // every emitting column summary becomes a result word
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (take && colv.emit) |=> out_valid_r)
    else $error("emitting position did not reach the result register");

endmodule

[rtl/edge_mask_border_dilation_top.sv]
// top level of the edge mask border dilation block
// Pixels enter in raster order, one word per clock while the result side
// does not stall, and each result word leaves radius rows plus radius
// pixels after its own pixel, i.e. after RADIUS*width+RADIUS further input
// words; the pipe itself registers each word in the column stage and the
// result register, with the horizontal window as logic between them. The rate
// of one word per clock is set by the column store, a single memory of one word
// per column read on entry and written back on leave of the same stage. Flush
// words after the frame drain one result each; when the frame holds fewer
// pixels than the lag, the first flush word holds the input off while empty
// positions are pushed through. No clearing pass is needed after reset.
module edge_mask_border_dilation_top import embd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  embd_in_if.sink              in_chan,
  embd_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             load_ok;
  logic             issue_valid;
  logic [COL_W-1:0] issue_col;
  issue_t           issue;
  logic             colv_valid;
  colv_t            colv;
  logic             win_ready;

  // counters and flush sequencing
  embd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load_ok     (load_ok),
    .issue_valid (issue_valid),
    .issue_col   (issue_col),
    .issue       (issue)
  );

  // column history and vertical or
  embd_colst #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_colst (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_col   (issue_col),
    .issue       (issue),
    .load_ok     (load_ok),
    .colv_valid  (colv_valid),
    .colv        (colv),
    .win_ready   (win_ready)
  );

  // horizontal window and result register
  embd_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .colv_valid (colv_valid),
    .colv       (colv),
    .win_ready  (win_ready),
    .out_chan   (out_chan)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// testbench for the edge mask border dilation block: random pixel streams checked word by word
module tb import embd_pkg::*; ();

  localparam int RADIUS       = 5;
  localparam int MAX_W        = 1024;
  localparam int RING_ROWS    = 3 * RADIUS + 2;
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_WORDS = 150;
  localparam int REPORT_MAX   = 10;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  embd_in_if  in_if ();
  embd_out_if out_if ();

  edge_mask_border_dilation_top #(
    .MAX_WIDTH(MAX_W),
    .RADIUS   (RADIUS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // stimulus and expectation stores
  in_item_t    word_q[$];     // input words waiting for the driver
  out_item_t   dilated_q[$];  // predicted result words, oldest first
  int unsigned words_open;    // queued or on the bus, not yet accepted
  bit          in_taken;
  bit          idle_on;
  bit          hold_req;
  int unsigned src_gap;
  int unsigned sink_wait;
  int unsigned error_cnt;

  // predictor state: ring of rows (bit 0 edge, bit 1 border) and frame position
  logic [1:0]       row_store [RING_ROWS][MAX_W];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      px_col;
  int unsigned      px_row;
  int unsigned      res_count;

  always #5 clk = ~clk;

  // out of range sizes: zero counts as one, above the top counts as the top
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    px_col    = 0;
    px_row    = 0;
    res_count = 0;
  endfunction

  // dilated border of the next pixel in raster order
  function automatic out_item_t border_result(int unsigned w, int unsigned h);
    int unsigned r;
    int unsigned c;
    int          rr;
    int          cc;
    logic        near_edge;
    logic [1:0]  centre;
    out_item_t   res;
    r         = res_count / w;
    c         = res_count % w;
    centre    = row_store[r % RING_ROWS][c];
    near_edge = 1'b0;
    // square window clipped at the frame edges
    for (int dr = -RADIUS; dr <= RADIUS; dr++) begin
      rr = int'(r) + dr;
      if (rr >= 0 && rr < int'(h)) begin
        for (int dc = -RADIUS; dc <= RADIUS; dc++) begin
          cc = int'(c) + dc;
          if (cc >= 0 && cc < int'(w) && row_store[rr % RING_ROWS][cc][0]) near_edge = 1'b1;
        end
      end
    end
    res.pixel_col  = PIX_W'(c);
    res.pixel_row  = PIX_W'(r);
    res.edge_out   = centre[0];
    res.border_out = centre[1] | (near_edge & ~centre[0]);
    res.frame_last = (res_count == w * h - 1);
    res_count++;
    if (res_count >= w * h) restart_frame();
    return res;
  endfunction

  // one accepted input word: store the pixel and predict any result it releases
  function automatic void dilate_word(in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned lag;
    int unsigned idx;
    w   = eff_dim(width_reg, MAX_W);
    h   = eff_dim(height_reg, MAX_HEIGHT);
    lag = RADIUS * w + RADIUS;
    if (it.req_type == REQ_PIXEL && px_row < h) begin
      idx = px_row * w + px_col;
      row_store[px_row % RING_ROWS][px_col] = {it.border_in, it.edge_bit};
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
      if (idx >= lag) dilated_q.push_back(border_result(w, h));
    end else if (px_row >= h && res_count < w * h) begin
      dilated_q.push_back(border_result(w, h));
    end
  endfunction

  function automatic string word_str(out_item_t x);
    return $sformatf("col %0d row %0d edge %0b border %0b last %0b",
                     x.pixel_col, x.pixel_row, x.edge_out, x.border_out, x.frame_last);
  endfunction

  function automatic void log_error(string msg);
    error_cnt++;
    if (error_cnt <= REPORT_MAX) $display("%0t %s", $time, msg);
  endfunction

  // input word driver
  always @(negedge clk) begin : drv
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_if.valid;
    nxt_data  = in_if.data;
    if (in_taken) begin
      in_taken  = 1'b0;
      nxt_valid = 1'b0;
    end
    if (!nxt_valid) begin
      if (src_gap != 0) begin
        src_gap--;
      end else if (word_q.size() != 0) begin
        nxt_data  = word_q.pop_front();
        nxt_valid = 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
      end
    end
    in_if.valid <= nxt_valid;
    in_if.data  <= nxt_data;
  end

  // result ready: random stall bursts and one long hold-off on request
  always @(negedge clk) begin : sink
    if (hold_req) begin
      hold_req  = 1'b0;
      sink_wait = LONG_HOLD;
    end else if (sink_wait == 0 && idle_on && $urandom_range(0, 9) == 0) begin
      sink_wait = $urandom_range(1, 17);
    end
    if (sink_wait != 0) begin
      sink_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor and predictor, both sampled at the rising edge
  always @(posedge clk) begin : chk
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      // result word against the oldest prediction
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (dilated_q.size() == 0) begin
          log_error({"result word with nothing expected: ", word_str(got)});
        end else begin
          want = dilated_q.pop_front();
          if (got.pixel_col !== want.pixel_col || got.pixel_row !== want.pixel_row ||
              got.edge_out !== want.edge_out || got.border_out !== want.border_out ||
              got.frame_last !== want.frame_last)
            log_error({"mismatch: expected ", word_str(want), ", got ", word_str(got)});
        end
      end
      // accepted input word
      if (in_if.valid && in_if.ready) begin
        dilate_word(in_if.data);
        words_open--;
        in_taken = 1'b1;
      end
    end
  end

  task automatic push_word(req_type_t req, logic e, logic b);
    in_item_t it;
    it.req_type  = req;
    it.edge_bit  = e;
    it.border_in = b;
    word_q.push_back(it);
    words_open++;
  endtask

  // pixels at a given edge density, then drain words; noisy adds stray flushes
  // among the pixels, pixels among the drain and flushes after the frame
  task automatic add_items(int unsigned n_pix, int unsigned n_drain, int unsigned pct, bit noisy);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        push_word(REQ_FLUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      push_word(REQ_PIXEL, $urandom_range(0, 99) < pct, $urandom_range(0, 3) == 0);
    end
    for (int unsigned i = 0; i < n_drain; i++)
      push_word((noisy && $urandom_range(0, 2) == 0) ? REQ_PIXEL : REQ_FLUSH,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (noisy)
      repeat ($urandom_range(1, 2))
        push_word(REQ_FLUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // block idle: all words taken, all results in, pipe settled
  task automatic wait_drained();
    while (words_open != 0 || dilated_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // both size registers, written back to back while idle
  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg  = w;
    height_reg = h;
    restart_frame();
  endtask

  initial begin : stim
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned drain;
    int unsigned pct;
    int unsigned pix;
    int unsigned random_words;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_FRAME_WIDTH;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    in_taken     = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    src_gap      = 0;
    sink_wait    = 0;
    error_cnt    = 0;
    words_open   = 0;
    width_reg    = DIM_RST;
    height_reg   = DIM_RST;
    restart_frame();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset sizes: stray flushes and a few pixels, well short of the lag
    push_word(REQ_FLUSH, 1'b1, 1'b1);
    push_word(REQ_PIXEL, 1'b1, 1'b1);
    push_word(REQ_PIXEL, 1'b0, 1'b0);
    push_word(REQ_FLUSH, 1'b0, 1'b0);
    wait_drained();

    // 3x2 frame, smaller than the lag, with a flush before the frame is in
    set_frame(CFG_W'(3), CFG_W'(2));
    push_word(REQ_PIXEL, 1'b0, 1'b0);
    push_word(REQ_FLUSH, 1'b1, 1'b0);
    push_word(REQ_PIXEL, 1'b1, 1'b0);
    push_word(REQ_PIXEL, 1'b0, 1'b1);
    push_word(REQ_PIXEL, 1'b0, 1'b0);
    push_word(REQ_PIXEL, 1'b1, 1'b1);
    push_word(REQ_PIXEL, 1'b0, 1'b0);
    repeat (5) push_word(REQ_FLUSH, 1'b0, 1'b1);
    // pixel past the frame drains as a flush, then a flush with nothing left
    push_word(REQ_PIXEL, 1'b1, 1'b0);
    push_word(REQ_FLUSH, 1'b1, 1'b1);
    wait_drained();

    // zero sizes count as a 1x1 frame
    set_frame(CFG_W'(0), CFG_W'(0));
    push_word(REQ_PIXEL, 1'b1, 1'b0);
    push_word(REQ_PIXEL, 1'b0, 1'b1);
    push_word(REQ_FLUSH, 1'b0, 1'b0);
    wait_drained();

    // long receiver hold-off while a full frame streams in
    set_frame(CFG_W'(16), CFG_W'(6));
    hold_req = 1'b1;
    add_items(96, 85, 20, 1'b0);
    wait_drained();

    // width above range clamps to the widest row: a short partial row gives nothing
    set_frame(11'd2047, 11'd0);
    add_items(30, 0, 2, 1'b1);
    wait_drained();

    // tall frame of one-pixel rows, cut short past row 512
    set_frame(CFG_W'(1), CFG_W'(1024));
    add_items(530, 0, 10, 1'b0);
    wait_drained();

    // partial frames cut short by a register write
    set_frame(CFG_W'(0), 11'd2047);
    add_items(60, 0, 20, 1'b1);
    wait_drained();
    set_frame(CFG_W'(1024), CFG_W'(1024));
    add_items(12, 0, 50, 1'b1);
    wait_drained();

    // random frames, mostly well formed
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if (random_words > RANDOM_WORDS * 4 / 5) idle_on = 1'b0;
      w = $urandom_range(1, 16);
      h = (w <= 8 && $urandom_range(0, 2) == 0) ? $urandom_range(18, 36) : $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(17, 64);
        h = $urandom_range(1, 4);
      end
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 1;
        2:       pct = 5;
        3:       pct = 20;
        default: pct = 60;
      endcase
      set_frame(CFG_W'(w), CFG_W'(h));
      total = w * h;
      drain = (RADIUS * w + RADIUS < total) ? RADIUS * w + RADIUS : total;
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 5))
          0: begin
            pix = $urandom_range(1, total);
            add_items(pix, 0, pct, 1'b1);
            random_words += pix;
          end
          1: begin
            add_items(total, drain, pct, 1'b1);
            random_words += total + drain;
          end
          default: begin
            add_items(total, drain, pct, 1'b0);
            random_words += total + drain;
          end
        endcase
      end
      wait_drained();
    end

    idle_on = 1'b0;
    wait_drained();
    if (error_cnt == 0 && dilated_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
